### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the header validator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### hdl/ncv_pkg.sv
// ----------------------------------------------------------------------------
// ncv_pkg
// Types and constants for the classic netCDF header validator.
// ----------------------------------------------------------------------------
package ncv_pkg;

   localparam int COUNT_BITS = 31;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [4:0] {
      PH_MAGIC, PH_NUMRECS, PH_TAG, PH_COUNT, PH_NAME_LEN, PH_NAME_BYTES,
      PH_NAME_PAD, PH_DIM_SIZE, PH_ATTR_TYPE, PH_ATTR_NELEMS, PH_ATTR_VALUES,
      PH_VALUE_PAD, PH_VAR_NDIMS, PH_VAR_DIMID, PH_VAR_TYPE, PH_VAR_VSIZE,
      PH_VAR_BEGIN, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_VALID = 3'd0, ST_BAD_SIG = 3'd1, ST_BAD_VER = 3'd2, ST_BAD_TAG = 3'd3,
      ST_BAD_TYPE = 3'd4, ST_BAD_PAD = 3'd5, ST_TRUNC = 3'd6, ST_TOO_BIG = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      SEC_DIM = 2'd0, SEC_GATT = 2'd1, SEC_VAR = 2'd2
   } section_type;

   localparam logic [31:0] TAG_DIMENSION = 32'h0000_000A;
   localparam logic [31:0] TAG_VARIABLE  = 32'h0000_000B;
   localparam logic [31:0] TAG_ATTRIBUTE = 32'h0000_000C;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] error_offset;
      logic [2:0]  format_version;
      logic [63:0] record_count;
      logic [30:0] dimension_count;
      logic [30:0] global_attribute_count;
      logic [30:0] variable_count;
   } rsp_type;

   function automatic logic [3:0] type_bytes(input logic [3:0] t);
      case (t)
         4'd1, 4'd2, 4'd7: type_bytes = 4'd1;
         4'd3, 4'd8:       type_bytes = 4'd2;
         4'd4, 4'd5, 4'd9: type_bytes = 4'd4;
         4'd6, 4'd10, 4'd11: type_bytes = 4'd8;
         default:          type_bytes = 4'd0;
      endcase
   endfunction

endpackage

### hdl/ncv_queue.sv
// ----------------------------------------------------------------------------
// ncv_queue
// Short word queue between the byte front end and the parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ncv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ncv_pkg::req_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output ncv_pkg::req_type pop_data
);
   ncv_pkg::req_type mem_ff [ncv_pkg::QUEUE_DEPTH];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'(ncv_pkg::QUEUE_DEPTH);
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !full || pop)
   `ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, !empty)
   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, cnt_ff <= 2'(ncv_pkg::QUEUE_DEPTH))
endmodule

### hdl/ncv_parser.sv
// ----------------------------------------------------------------------------
// ncv_parser
// Header grammar FSM; one byte per cycle unless stalled; registered result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ncv_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ncv_pkg::req_type in_word,
   output logic             in_take,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ncv_pkg::rsp_type rsp_data
);
   ncv_pkg::phase_type   ph_ff, ph_in;
   ncv_pkg::section_type sec_ff, sec_in;
   logic [3:0]  fbl_ff, fbl_in, esz_ff, esz_in;
   logic [63:0] acc_ff, acc_in, pay_ff, pay_in, off_ff, off_in, rec_ff, rec_in;
   logic [2:0]  ver_ff, ver_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] outer_ff, outer_in, inner_ff, inner_in, dims_ff, dims_in;
   logic [1:0]  pad_ff, pad_in;
   logic        iva_ff, iva_in, fin_ff, fin_in;
   logic [30:0] dseen_ff, dseen_in, gseen_ff, gseen_in, vseen_ff, vseen_in;
   logic        ov_ff, ov_in;
   ncv_pkg::rsp_type ob_ff, ob_in;

   logic [7:0]  b;
   logic [63:0] v, off, nxt;
   logic [3:0]  nn;
   logic        done;
   logic [2:0]  st;
   logic [63:0] where;
   logic [31:0] expect_tag;
   logic        big;

   assign in_take   = in_valid && (!ov_ff || rsp_ready);
   assign rsp_valid = ov_ff;
   assign rsp_data  = ob_ff;

   always_comb begin
      logic        pf, sof_r;
      logic [1:0]  padn;
      ncv_pkg::phase_type padph;
      b = in_word.data_byte;
      ph_in = ph_ff; sec_in = sec_ff; fbl_in = fbl_ff; esz_in = esz_ff;
      acc_in = acc_ff; pay_in = pay_ff; off_in = off_ff; rec_in = rec_ff;
      ver_in = ver_ff; tag_in = tag_ff; outer_in = outer_ff; inner_in = inner_ff;
      dims_in = dims_ff; pad_in = pad_ff; iva_in = iva_ff; fin_in = fin_ff;
      dseen_in = dseen_ff; gseen_in = gseen_ff; vseen_in = vseen_ff;
      ov_in = ov_ff && !rsp_ready; ob_in = ob_ff;
      done = 1'b0; st = ncv_pkg::ST_VALID; where = '0;
      pf = 1'b0; padn = 2'd0; padph = ncv_pkg::PH_NAME_PAD;
      sof_r = in_word.start_of_file;
      v = '0; nn = 4'd4; expect_tag = '0; big = 1'b0; off = '0; nxt = '0;
      if (in_take) begin
         if (sof_r) begin
            ph_in = ncv_pkg::PH_MAGIC; sec_in = ncv_pkg::SEC_DIM; fbl_in = '0;
            esz_in = '0; acc_in = '0; pay_in = '0; off_in = '0; rec_in = '0;
            ver_in = '0; tag_in = '0; outer_in = '0; inner_in = '0; dims_in = '0;
            pad_in = '0; iva_in = 1'b0; fin_in = 1'b0;
            dseen_in = '0; gseen_in = '0; vseen_in = '0;
         end
         nn = (ver_in == 3'd5) ? 4'd8 : 4'd4;
         off = off_in;
         nxt = off + 64'd1;
         if (!fin_in) begin
            off_in = nxt;
            v = {acc_in[55:0], b};
            case (ph_in)
               ncv_pkg::PH_MAGIC: begin
                  if (fbl_in < 4'd3) begin
                     if (b != ((fbl_in == 4'd0) ? 8'h43 : (fbl_in == 4'd1) ? 8'h44 : 8'h46))
                     begin
                        done = 1'b1; st = ncv_pkg::ST_BAD_SIG; where = off;
                     end
                     fbl_in = fbl_in + 4'd1;
                  end else if (b != 8'd1 && b != 8'd2 && b != 8'd5) begin
                     done = 1'b1; st = ncv_pkg::ST_BAD_VER; where = off;
                  end else begin
                     ver_in = b[2:0];
                     ph_in = ncv_pkg::PH_NUMRECS;
                     fbl_in = (b == 8'd5) ? 4'd8 : 4'd4;
                     acc_in = '0;
                  end
               end
               ncv_pkg::PH_NAME_BYTES, ncv_pkg::PH_ATTR_VALUES: begin
                  if (fbl_in > 4'd1) fbl_in = fbl_in - 4'd1;
                  else begin
                     fbl_in = esz_in;
                     if (pay_in != '0) pay_in = pay_in - 64'd1;
                     if (pay_in == '0) begin
                        padph = (ph_in == ncv_pkg::PH_NAME_BYTES) ?
                                ncv_pkg::PH_NAME_PAD : ncv_pkg::PH_VALUE_PAD;
                        if (pad_in != 2'd0) ph_in = padph;
                        else pf = 1'b1;
                     end
                  end
               end
               ncv_pkg::PH_NAME_PAD, ncv_pkg::PH_VALUE_PAD: begin
                  if (b != 8'd0) begin
                     done = 1'b1; st = ncv_pkg::ST_BAD_PAD; where = off;
                  end else begin
                     if (pad_in != 2'd0) pad_in = pad_in - 2'd1;
                     if (pad_in == 2'd0) begin
                        pf = 1'b1; padph = ph_in;
                     end
                  end
               end
               ncv_pkg::PH_DONE: ;
               default: begin
                  acc_in = v;
                  if (fbl_in > 4'd1) fbl_in = fbl_in - 4'd1;
                  else begin
                     fbl_in = '0;
                     big = v[63:ncv_pkg::COUNT_BITS] != '0;
                     case (ph_in)
                        ncv_pkg::PH_NUMRECS: begin
                           rec_in = v; ph_in = ncv_pkg::PH_TAG; fbl_in = 4'd4; acc_in = '0;
                        end
                        ncv_pkg::PH_TAG: begin
                           tag_in = v[31:0]; ph_in = ncv_pkg::PH_COUNT;
                           fbl_in = nn; acc_in = '0;
                        end
                        ncv_pkg::PH_COUNT: begin
                           expect_tag = (iva_in || sec_in == ncv_pkg::SEC_GATT) ?
                              ncv_pkg::TAG_ATTRIBUTE : (sec_in == ncv_pkg::SEC_DIM) ?
                              ncv_pkg::TAG_DIMENSION : ncv_pkg::TAG_VARIABLE;
                           if (tag_in != ((v == '0) ? 32'd0 : expect_tag)) begin
                              done = 1'b1; st = ncv_pkg::ST_BAD_TAG;
                              where = nxt - 64'(4'd4 + nn);
                           end else if (big) begin
                              done = 1'b1; st = ncv_pkg::ST_TOO_BIG; where = nxt - 64'(nn);
                           end else begin
                              if (iva_in) inner_in = v[31:0];
                              else begin
                                 outer_in = v[31:0];
                                 case (sec_in)
                                    ncv_pkg::SEC_DIM:  dseen_in = v[30:0];
                                    ncv_pkg::SEC_GATT: gseen_in = v[30:0];
                                    default:           vseen_in = v[30:0];
                                 endcase
                              end
                              ph_in = ncv_pkg::PH_VALUE_PAD; pf = 1'b1;
                              padph = ncv_pkg::PH_VALUE_PAD;
                           end
                        end
                        ncv_pkg::PH_NAME_LEN, ncv_pkg::PH_ATTR_NELEMS: begin
                           if (big) begin
                              done = 1'b1; st = ncv_pkg::ST_TOO_BIG; where = nxt - 64'(nn);
                           end else begin
                              if (ph_in == ncv_pkg::PH_NAME_LEN) esz_in = 4'd1;
                              pay_in = v;
                              padn = 2'(v[1:0] * esz_in[1:0]);
                              pad_in = 2'd0 - padn;
                              padph = (ph_in == ncv_pkg::PH_NAME_LEN) ?
                                      ncv_pkg::PH_NAME_PAD : ncv_pkg::PH_VALUE_PAD;
                              if (v != '0) begin
                                 ph_in = (ph_in == ncv_pkg::PH_NAME_LEN) ?
                                    ncv_pkg::PH_NAME_BYTES : ncv_pkg::PH_ATTR_VALUES;
                                 fbl_in = esz_in;
                              end else if (pad_in != 2'd0) ph_in = padph;
                              else pf = 1'b1;
                           end
                        end
                        ncv_pkg::PH_DIM_SIZE, ncv_pkg::PH_VAR_BEGIN: begin
                           pf = 1'b1; padph = ncv_pkg::PH_VALUE_PAD;
                        end
                        ncv_pkg::PH_ATTR_TYPE, ncv_pkg::PH_VAR_TYPE: begin
                           if (v < 64'd1 || v > 64'd11) begin
                              done = 1'b1; st = ncv_pkg::ST_BAD_TYPE; where = off - 64'd3;
                           end else begin
                              if (ph_in == ncv_pkg::PH_ATTR_TYPE) begin
                                 esz_in = ncv_pkg::type_bytes(v[3:0]);
                                 ph_in = ncv_pkg::PH_ATTR_NELEMS;
                              end else ph_in = ncv_pkg::PH_VAR_VSIZE;
                              fbl_in = nn; acc_in = '0;
                           end
                        end
                        ncv_pkg::PH_VAR_NDIMS, ncv_pkg::PH_VAR_DIMID: begin
                           if (ph_in == ncv_pkg::PH_VAR_NDIMS && big) begin
                              done = 1'b1; st = ncv_pkg::ST_TOO_BIG; where = nxt - 64'(nn);
                           end else begin
                              if (ph_in == ncv_pkg::PH_VAR_NDIMS) dims_in = v[31:0];
                              else if (dims_in != '0) dims_in = dims_in - 32'd1;
                              acc_in = '0;
                              if (dims_in != '0) begin
                                 ph_in = ncv_pkg::PH_VAR_DIMID; fbl_in = nn;
                              end else begin
                                 iva_in = 1'b1; ph_in = ncv_pkg::PH_TAG; fbl_in = 4'd4;
                              end
                           end
                        end
                        ncv_pkg::PH_VAR_VSIZE: begin
                           ph_in = ncv_pkg::PH_VAR_BEGIN; acc_in = '0;
                           fbl_in = (ver_in == 3'd1) ? 4'd4 : 4'd8;
                        end
                        default: ;
                     endcase
                  end
               end
            endcase
            if (pf) begin
               acc_in = '0;
               if (padph == ncv_pkg::PH_VALUE_PAD) begin
                  if (iva_in) begin
                     if (inner_in != '0) begin
                        inner_in = inner_in - 32'd1;
                        ph_in = ncv_pkg::PH_NAME_LEN; fbl_in = nn;
                     end else begin
                        iva_in = 1'b0; ph_in = ncv_pkg::PH_VAR_TYPE; fbl_in = 4'd4;
                     end
                  end else if (outer_in != '0) begin
                     outer_in = outer_in - 32'd1;
                     ph_in = ncv_pkg::PH_NAME_LEN; fbl_in = nn;
                  end else if (sec_in == ncv_pkg::SEC_DIM) begin
                     sec_in = ncv_pkg::SEC_GATT; ph_in = ncv_pkg::PH_TAG; fbl_in = 4'd4;
                  end else if (sec_in == ncv_pkg::SEC_GATT) begin
                     sec_in = ncv_pkg::SEC_VAR; ph_in = ncv_pkg::PH_TAG; fbl_in = 4'd4;
                  end else begin
                     ph_in = ncv_pkg::PH_DONE; done = 1'b1;
                     st = ncv_pkg::ST_VALID; where = nxt;
                  end
               end else if (iva_in || sec_in == ncv_pkg::SEC_GATT) begin
                  ph_in = ncv_pkg::PH_ATTR_TYPE; fbl_in = 4'd4;
               end else if (sec_in == ncv_pkg::SEC_DIM) begin
                  ph_in = ncv_pkg::PH_DIM_SIZE; fbl_in = nn;
               end else begin
                  ph_in = ncv_pkg::PH_VAR_NDIMS; fbl_in = nn;
               end
            end
            if (!done && in_word.end_of_file) begin
               done = 1'b1; st = ncv_pkg::ST_TRUNC; where = nxt;
            end
            if (done) begin
               fin_in = 1'b1;
               ov_in  = 1'b1;
               ob_in.status = st;
               ob_in.error_offset = where;
               ob_in.format_version = ver_in;
               ob_in.record_count = rec_in;
               ob_in.dimension_count = dseen_in;
               ob_in.global_attribute_count = gseen_in;
               ob_in.variable_count = vseen_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= ncv_pkg::PH_MAGIC; sec_ff <= ncv_pkg::SEC_DIM; fbl_ff <= '0;
         esz_ff <= '0; acc_ff <= '0; pay_ff <= '0; off_ff <= '0; rec_ff <= '0;
         ver_ff <= '0; tag_ff <= '0; outer_ff <= '0; inner_ff <= '0; dims_ff <= '0;
         pad_ff <= '0; iva_ff <= 1'b0; fin_ff <= 1'b0;
         dseen_ff <= '0; gseen_ff <= '0; vseen_ff <= '0; ov_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; sec_ff <= sec_in; fbl_ff <= fbl_in; esz_ff <= esz_in;
         acc_ff <= acc_in; pay_ff <= pay_in; off_ff <= off_in; rec_ff <= rec_in;
         ver_ff <= ver_in; tag_ff <= tag_in; outer_ff <= outer_in;
         inner_ff <= inner_in; dims_ff <= dims_in; pad_ff <= pad_in;
         iva_ff <= iva_in; fin_ff <= fin_in; dseen_ff <= dseen_in;
         gseen_ff <= gseen_in; vseen_ff <= vseen_in; ov_ff <= ov_in;
      end
      ob_ff <= ob_in;
   end

   `ASSERT_NEXT(a_result_latches_fin, clock, reset, done && in_take, fin_ff && ov_ff)
   `ASSERT_IMPLIES(a_held_until_taken, clock, reset, ov_ff && !rsp_ready, !in_take || in_valid)
   `ASSERT_IMPLIES(a_version_legal, clock, reset, 1'b1,
      ver_ff == 3'd0 || ver_ff == 3'd1 || ver_ff == 3'd2 || ver_ff == 3'd5)
endmodule

### hdl/netcdf_header_validator_unit.sv
// ----------------------------------------------------------------------------
// netcdf_header_validator_unit
// Streaming checker for classic netCDF (CDF-1/2/5) file headers.
// ----------------------------------------------------------------------------
// channel  dir  word        handshake
// req      in   req_type    req_valid / req_ready
// rsp      out  rsp_type    rsp_valid / rsp_ready
//
// One byte per cycle; the two-entry queue absorbs front/back stalls.
// The result register loads when the parser takes from the queue the byte
// that ends or breaks the header.
// The parser stalls only while a result is held and rsp_ready is low.
// Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module netcdf_header_validator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ncv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ncv_pkg::rsp_type rsp_data
);
   logic             q_full, q_empty, q_pop;
   ncv_pkg::req_type q_data;

   assign req_ready = !q_full;

   ncv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_data (req_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   ncv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_word   (q_data),
      .in_take   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
